/* sv/bdac_pkg.sv */
// ============================================================================
// bdac_pkg
// Shared constants, types and state codes of the binned autocorrelation unit.
// ============================================================================
package bdac_pkg;

  localparam int PTS_MAX   = 1024;
  localparam int PT_AW     = $clog2(PTS_MAX);
  localparam int PT_CW     = $clog2(PTS_MAX + 1);
  localparam int BIN_MAX   = 64;
  localparam int BIN_AW    = $clog2(BIN_MAX);
  localparam int BIN_CW    = $clog2(BIN_MAX + 1);

  localparam int DIV_NUM_W = 88;
  localparam int DIV_W     = 64;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  // dividend widths of the divider uses
  localparam logic [DIV_CNT_W-1:0] NB_WEIGHT = DIV_CNT_W'(48);
  localparam logic [DIV_CNT_W-1:0] NB_MEAN   = DIV_CNT_W'(88);
  localparam logic [DIV_CNT_W-1:0] NB_Z      = DIV_CNT_W'(45);
  localparam logic [DIV_CNT_W-1:0] NB_BIN    = DIV_CNT_W'(36);
  localparam logic [DIV_CNT_W-1:0] NB_CORR   = DIV_CNT_W'(63);
  localparam logic [DIV_CNT_W-1:0] NB_ERR    = DIV_CNT_W'(32);

  localparam logic [63:0] Z_LIMIT = 64'h0000_0000_7FFF_FFFF;

  // configuration register indexes
  localparam logic [1:0] CFG_LAG_MIN  = 2'd0;
  localparam logic [1:0] CFG_LAG_STEP = 2'd1;
  localparam logic [1:0] CFG_BINS     = 2'd2;

  typedef struct packed {
    logic [31:0] ptime;
    logic [47:0] data;   // {magnitude, uncertainty}, later {z, 16'b0}
  } point_word_t;

  typedef struct packed {
    logic signed [63:0] corr;
    logic [63:0]        esum;
    logic [19:0]        cnt;
  } bin_word_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_W-1:0]     den;
    logic [DIV_CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] value;
  } sq_req_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_CLEAR,
    ST_W_RD, ST_W_SQ, ST_W_DIV, ST_W_WAIT, ST_W_M0, ST_W_M1, ST_W_ADD,
    ST_MEAN, ST_MEAN_WAIT,
    ST_Z_RD, ST_Z_DIV, ST_Z_WAIT,
    ST_P_I, ST_P_IL, ST_P_J, ST_P_BIN, ST_P_BWAIT, ST_P_M0, ST_P_M1, ST_P_M2,
    ST_P_UPD,
    ST_O_START, ST_O_RD, ST_O_CHK, ST_O_CWAIT, ST_O_SQRT, ST_O_EWAIT, ST_O_EMIT,
    ST_O_EMPTY
  } state_t;

endpackage

/* sv/binned_discrete_autocorrelation_unit.sv */
// ============================================================================
// binned_discrete_autocorrelation_unit
// Loads a sampled series, then walks all point pairs into lag bins and
// reports mean correlation, error and pair count for every bin with at least two pairs.
// ============================================================================
//
// channel  direction  handshake            payload
// -------  ---------  -------------------  ---------------------------------
// in       into       in_valid/in_ready    sample_time magnitude uncertainty
//                                          final_point
// out      out of     out_valid/out_ready  lag correlation correlation_error
//                                          pair_count points_dropped last_bin
// cfg      into       cfg_valid/cfg_ready  cfg_index cfg_data
//
// Loading takes one point request per cycle while the unit is in its load state. The
// final point starts the evaluation: a bin clear, a weight per point, the
// mean, a z per point, then the pair walk (N*(N+1)/2 pairs) in which the
// bit-serial divider bins each gap, and per reported bin the divider, the
// square root and the divider again.
// Reset is synchronous; the bin store needs no clearing pass after reset,
// it is swept at the start of every evaluation. Output results sit in a
// register, so a stalled last result does not block the next series load.
// ============================================================================
module binned_discrete_autocorrelation_unit (
  input  logic               clk,
  input  logic               rst,
  // point requests
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        sample_time,
  input  logic signed [23:0] magnitude,
  input  logic [23:0]        uncertainty,
  input  logic               final_point,
  // result requests
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        lag,
  output logic signed [31:0] correlation,
  output logic [31:0]        correlation_error,
  output logic [19:0]        pair_count,
  output logic               points_dropped,
  output logic               last_bin,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic signed [65:0] CSUM_MAX = 66'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [65:0] CSUM_MIN = -66'sh0_7FFF_FFFF_FFFF_FFFF;

  bdac_pkg::state_t state, state_next;

  // configuration
  logic [31:0] lag_min;
  logic [31:0] lag_step;
  logic [6:0]  bins_in_use;
  logic [6:0]  nb_eff;
  logic [32:0] step;

  // counters
  logic [bdac_pkg::PT_CW-1:0]  n_pts;
  logic [bdac_pkg::PT_CW-1:0]  i_idx;
  logic [bdac_pkg::PT_CW-1:0]  j_idx;
  logic [bdac_pkg::BIN_CW-1:0] b_idx;
  logic [bdac_pkg::BIN_CW-1:0] k_cnt;
  logic [bdac_pkg::BIN_CW-1:0] total;
  logic                        ovf;
  logic                        i_last;
  logic                        j_last;
  logic                        k_last;

  // datapath registers
  logic [63:0]        sw;
  logic [87:0]        acc_p;
  logic [87:0]        acc_n;
  logic [47:0]        wq;
  logic signed [25:0] mean;
  logic [31:0]        ti;
  logic [31:0]        zi;
  logic [31:0]        zj;
  logic [bdac_pkg::BIN_AW-1:0] bin_a;
  logic [63:0]        prod;
  logic [63:0]        pij;
  logic [63:0]        psq;
  logic [31:0]        lag_r;
  logic [31:0]        corr_r;
  logic [31:0]        err_r;

  // point memory: time plus value/uncertainty, later time plus z
  bdac_pkg::point_word_t pt_mem [bdac_pkg::PTS_MAX];
  bdac_pkg::point_word_t pt_rd;
  bdac_pkg::point_word_t pt_wr_data;
  logic                        pt_rd_en;
  logic                        pt_wr_en;
  logic [bdac_pkg::PT_AW-1:0]  pt_rd_addr;
  logic [bdac_pkg::PT_AW-1:0]  pt_wr_addr;

  // bin memory: correlation sum, error sum, pair count
  bdac_pkg::bin_word_t bin_mem [bdac_pkg::BIN_MAX];
  bdac_pkg::bin_word_t bin_rd;
  bdac_pkg::bin_word_t bin_wr_data;
  logic                        bin_rd_en;
  logic                        bin_wr_en;
  logic [bdac_pkg::BIN_AW-1:0] bin_rd_addr;
  logic [bdac_pkg::BIN_AW-1:0] bin_wr_addr;

  // shared units
  bdac_pkg::div_req_t div_req;
  logic               div_done;
  logic [63:0]        div_quo;
  logic [63:0]        div_rem;
  bdac_pkg::sq_req_t  sq_req;
  logic               sq_done;
  logic [31:0]        sq_root;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;

  logic in_fire;
  logic out_load;
  logic pair_adv;

  // combinational datapath
  logic [23:0]        rd_e;
  logic [23:0]        rd_s;
  logic [23:0]        rd_am;
  logic               rd_mneg;
  logic               acc_neg;
  logic [87:0]        mdiff;
  logic [63:0]        mq_r;
  logic signed [26:0] zd;
  logic [26:0]        zad;
  logic [44:0]        znum;
  logic [30:0]        zmag;
  logic [31:0]        z_val;
  logic [31:0]        tj;
  logic [31:0]        gap;
  logic [35:0]        bnum;
  logic               bin_over;
  logic [31:0]        zi_abs;
  logic [31:0]        zj_abs;
  logic signed [65:0] csum;
  logic [63:0]        csat;
  logic [63:0]        sq_sum;
  logic [64:0]        esum65;
  logic [63:0]        esat;
  logic [19:0]        cnt_inc;
  logic [37:0]        lag_mul;
  logic [38:0]        lag_sum;
  logic [31:0]        lag_sat;
  logic [63:0]        cmag;
  logic [30:0]        cq;
  logic [31:0]        corr_val;

  bdac_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  bdac_isqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (sq_req),
    .done (sq_done),
    .root (sq_root)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == bdac_pkg::ST_LOAD);
  assign in_fire   = in_valid && in_ready;

  assign nb_eff = (bins_in_use == 7'd0) ? 7'd1 :
                  (bins_in_use > 7'(bdac_pkg::BIN_MAX)) ? 7'(bdac_pkg::BIN_MAX) :
                  bins_in_use;
  assign step   = (lag_step == 32'd0) ? 33'd1 : {1'b0, lag_step};

  assign i_last = (i_idx + bdac_pkg::PT_CW'(1)) == n_pts;
  assign j_last = (j_idx + bdac_pkg::PT_CW'(1)) == n_pts;
  assign k_last = (k_cnt + bdac_pkg::BIN_CW'(1)) == total;

  // point fields (zero uncertainty behaves as one lsb)
  assign rd_e    = pt_rd.data[23:0];
  assign rd_s    = (rd_e == 24'd0) ? 24'd1 : rd_e;
  assign rd_mneg = pt_rd.data[47];
  assign rd_am   = rd_mneg ? (~pt_rd.data[47:24] + 24'd1) : pt_rd.data[47:24];

  // weighted mean, rounded half away from zero
  assign acc_neg = acc_n > acc_p;
  assign mdiff   = acc_neg ? (acc_n - acc_p) : (acc_p - acc_n);
  assign mq_r    = div_quo + ((div_rem >= (sw - div_rem)) ? 64'd1 : 64'd0);

  // z = (m - mean) / s in Q16.16
  assign zd    = {{3{pt_rd.data[47]}}, pt_rd.data[47:24]} - {mean[25], mean};
  assign zad   = zd[26] ? 27'(-zd) : 27'(zd);
  assign znum  = {1'b0, zad, 17'b0} + {21'b0, rd_s};
  assign zmag  = (div_quo > bdac_pkg::Z_LIMIT) ? 31'h7FFF_FFFF : div_quo[30:0];
  assign z_val = zd[26] ? (32'd0 - {1'b0, zmag}) : {1'b0, zmag};

  // gap binning: floor((2*gap - 2*lag_min + step) / (2*step))
  assign tj       = pt_rd.ptime;
  assign gap      = (ti > tj) ? (ti - tj) : (tj - ti);
  assign bnum     = {3'b0, gap, 1'b0} - {3'b0, lag_min, 1'b0} + {3'b0, step};
  assign bin_over = div_quo >= {57'b0, nb_eff};

  assign zi_abs = zi[31] ? (32'd0 - zi) : zi;
  assign zj_abs = zj[31] ? (32'd0 - zj) : zj;

  // saturating bin updates
  assign csum    = (zi[31] ^ zj[31]) ?
                   ({{2{bin_rd.corr[63]}}, bin_rd.corr} - $signed({2'b0, pij})) :
                   ({{2{bin_rd.corr[63]}}, bin_rd.corr} + $signed({2'b0, pij}));
  assign csat    = (csum > CSUM_MAX) ? CSUM_MAX[63:0] :
                   (csum < CSUM_MIN) ? CSUM_MIN[63:0] : csum[63:0];
  assign sq_sum  = psq + prod;
  assign esum65  = {1'b0, bin_rd.esum} + {1'b0, sq_sum};
  assign esat    = esum65[64] ? {64{1'b1}} : esum65[63:0];
  assign cnt_inc = (bin_rd.cnt == {20{1'b1}}) ? bin_rd.cnt : (bin_rd.cnt + 20'd1);

  // result fields
  assign lag_mul  = {32'b0, b_idx[bdac_pkg::BIN_AW-1:0]} * {6'b0, lag_step};
  assign lag_sum  = {7'b0, lag_min} + {1'b0, lag_mul};
  assign lag_sat  = (lag_sum[38:32] != 7'd0) ? 32'hFFFF_FFFF : lag_sum[31:0];
  assign cmag     = bin_rd.corr[63] ? (64'd0 - bin_rd.corr) : bin_rd.corr;
  assign cq       = (div_quo > bdac_pkg::Z_LIMIT) ? 31'h7FFF_FFFF : div_quo[30:0];
  assign corr_val = bin_rd.corr[63] ? (32'd0 - {1'b0, cq}) : {1'b0, cq};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bdac_pkg::ST_LOAD:      if (in_fire && final_point) state_next = bdac_pkg::ST_CLEAR;
      bdac_pkg::ST_CLEAR:
        if (b_idx == bdac_pkg::BIN_CW'(bdac_pkg::BIN_MAX - 1)) state_next = bdac_pkg::ST_W_RD;
      bdac_pkg::ST_W_RD:      state_next = bdac_pkg::ST_W_SQ;
      bdac_pkg::ST_W_SQ:      state_next = bdac_pkg::ST_W_DIV;
      bdac_pkg::ST_W_DIV:     state_next = bdac_pkg::ST_W_WAIT;
      bdac_pkg::ST_W_WAIT:    if (div_done) state_next = bdac_pkg::ST_W_M0;
      bdac_pkg::ST_W_M0:      state_next = bdac_pkg::ST_W_M1;
      bdac_pkg::ST_W_M1:      state_next = bdac_pkg::ST_W_ADD;
      bdac_pkg::ST_W_ADD:     state_next = i_last ? bdac_pkg::ST_MEAN : bdac_pkg::ST_W_RD;
      bdac_pkg::ST_MEAN:
        state_next = (sw == 64'd0) ? bdac_pkg::ST_Z_RD : bdac_pkg::ST_MEAN_WAIT;
      bdac_pkg::ST_MEAN_WAIT: if (div_done) state_next = bdac_pkg::ST_Z_RD;
      bdac_pkg::ST_Z_RD:      state_next = bdac_pkg::ST_Z_DIV;
      bdac_pkg::ST_Z_DIV:     state_next = bdac_pkg::ST_Z_WAIT;
      bdac_pkg::ST_Z_WAIT:
        if (div_done) state_next = i_last ? bdac_pkg::ST_P_I : bdac_pkg::ST_Z_RD;
      bdac_pkg::ST_P_I:       state_next = bdac_pkg::ST_P_IL;
      bdac_pkg::ST_P_IL:      state_next = bdac_pkg::ST_P_J;
      bdac_pkg::ST_P_J:       state_next = bdac_pkg::ST_P_BIN;
      bdac_pkg::ST_P_BIN:     state_next = bdac_pkg::ST_P_BWAIT;
      bdac_pkg::ST_P_BWAIT:   if (div_done && !bin_over) state_next = bdac_pkg::ST_P_M0;
      bdac_pkg::ST_P_M0:      state_next = bdac_pkg::ST_P_M1;
      bdac_pkg::ST_P_M1:      state_next = bdac_pkg::ST_P_M2;
      bdac_pkg::ST_P_M2:      state_next = bdac_pkg::ST_P_UPD;
      bdac_pkg::ST_O_START:
        state_next = (total == '0) ? bdac_pkg::ST_O_EMPTY : bdac_pkg::ST_O_RD;
      bdac_pkg::ST_O_RD:      state_next = bdac_pkg::ST_O_CHK;
      bdac_pkg::ST_O_CHK:
        state_next = (bin_rd.cnt <= 20'd1) ? bdac_pkg::ST_O_RD : bdac_pkg::ST_O_CWAIT;
      bdac_pkg::ST_O_CWAIT:   if (div_done) state_next = bdac_pkg::ST_O_SQRT;
      bdac_pkg::ST_O_SQRT:    if (sq_done) state_next = bdac_pkg::ST_O_EWAIT;
      bdac_pkg::ST_O_EWAIT:   if (div_done) state_next = bdac_pkg::ST_O_EMIT;
      bdac_pkg::ST_O_EMIT:
        if (!out_valid || out_ready)
          state_next = k_last ? bdac_pkg::ST_LOAD : bdac_pkg::ST_O_RD;
      bdac_pkg::ST_O_EMPTY:   if (!out_valid || out_ready) state_next = bdac_pkg::ST_LOAD;
      default:                state_next = bdac_pkg::ST_LOAD;
    endcase
    // pair walk: next pair or leave
    if (pair_adv)
      state_next = j_last ? (i_last ? bdac_pkg::ST_O_START : bdac_pkg::ST_P_I)
                          : bdac_pkg::ST_P_J;
  end

  // control outputs
  always_comb begin
    pt_rd_en    = 1'b0;
    pt_rd_addr  = i_idx[bdac_pkg::PT_AW-1:0];
    pt_wr_en    = 1'b0;
    pt_wr_addr  = i_idx[bdac_pkg::PT_AW-1:0];
    pt_wr_data  = '{ptime: pt_rd.ptime, data: {z_val, 16'b0}};
    bin_rd_en   = 1'b0;
    bin_rd_addr = b_idx[bdac_pkg::BIN_AW-1:0];
    bin_wr_en   = 1'b0;
    bin_wr_addr = bin_a;
    bin_wr_data = '{corr: csat, esum: esat, cnt: cnt_inc};
    div_req     = '0;
    sq_req      = '{start: 1'b0, value: bin_rd.esum};
    mul_a       = zi_abs;
    mul_b       = zj_abs;
    out_load    = 1'b0;
    pair_adv    = 1'b0;
    case (state)
      bdac_pkg::ST_LOAD: begin
        pt_wr_en   = in_fire && (n_pts < bdac_pkg::PT_CW'(bdac_pkg::PTS_MAX));
        pt_wr_addr = n_pts[bdac_pkg::PT_AW-1:0];
        pt_wr_data = '{ptime: sample_time, data: {magnitude, uncertainty}};
      end
      bdac_pkg::ST_CLEAR: begin
        bin_wr_en   = 1'b1;
        bin_wr_addr = b_idx[bdac_pkg::BIN_AW-1:0];
        bin_wr_data = '0;
      end
      bdac_pkg::ST_W_RD: pt_rd_en = 1'b1;
      bdac_pkg::ST_W_SQ: begin
        mul_a = {8'b0, rd_s};
        mul_b = {8'b0, rd_s};
      end
      bdac_pkg::ST_W_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = 88'h1 << 47;
        div_req.den   = {16'b0, prod[47:0]};
        div_req.nbits = bdac_pkg::NB_WEIGHT;
      end
      bdac_pkg::ST_W_M0: begin
        mul_a = {8'b0, rd_am};
        mul_b = wq[31:0];
      end
      bdac_pkg::ST_W_M1: begin
        mul_a = {8'b0, rd_am};
        mul_b = {16'b0, wq[47:32]};
      end
      bdac_pkg::ST_MEAN: begin
        div_req.start = (sw != 64'd0);
        div_req.num   = mdiff;
        div_req.den   = sw;
        div_req.nbits = bdac_pkg::NB_MEAN;
      end
      bdac_pkg::ST_Z_RD: pt_rd_en = 1'b1;
      bdac_pkg::ST_Z_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = {43'b0, znum};
        div_req.den   = {39'b0, rd_s, 1'b0};
        div_req.nbits = bdac_pkg::NB_Z;
      end
      bdac_pkg::ST_Z_WAIT: pt_wr_en = div_done;
      bdac_pkg::ST_P_I: pt_rd_en = 1'b1;
      bdac_pkg::ST_P_J: begin
        pt_rd_en   = 1'b1;
        pt_rd_addr = j_idx[bdac_pkg::PT_AW-1:0];
      end
      bdac_pkg::ST_P_BIN: begin
        div_req.start = !bnum[35];
        div_req.num   = {52'b0, bnum};
        div_req.den   = {30'b0, step, 1'b0};
        div_req.nbits = bdac_pkg::NB_BIN;
        pair_adv      = bnum[35];
      end
      bdac_pkg::ST_P_BWAIT: begin
        bin_rd_en   = div_done && !bin_over;
        bin_rd_addr = div_quo[bdac_pkg::BIN_AW-1:0];
        pair_adv    = div_done && bin_over;
      end
      bdac_pkg::ST_P_M1: mul_b = zi_abs;
      bdac_pkg::ST_P_M2: mul_a = zj_abs;
      bdac_pkg::ST_P_UPD: begin
        bin_wr_en = 1'b1;
        pair_adv  = 1'b1;
      end
      bdac_pkg::ST_O_RD: bin_rd_en = 1'b1;
      bdac_pkg::ST_O_CHK: begin
        div_req.start = (bin_rd.cnt > 20'd1);
        div_req.num   = {24'b0, cmag};
        div_req.den   = {28'b0, bin_rd.cnt, 16'b0};
        div_req.nbits = bdac_pkg::NB_CORR;
      end
      bdac_pkg::ST_O_CWAIT: sq_req.start = div_done;
      bdac_pkg::ST_O_SQRT: begin
        div_req.start = sq_done;
        div_req.num   = {56'b0, sq_root};
        div_req.den   = {44'b0, bin_rd.cnt};
        div_req.nbits = bdac_pkg::NB_ERR;
      end
      bdac_pkg::ST_O_EMIT:  out_load = !out_valid || out_ready;
      bdac_pkg::ST_O_EMPTY: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (pt_wr_en) pt_mem[pt_wr_addr] <= pt_wr_data;
    if (pt_rd_en) pt_rd <= pt_mem[pt_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (bin_wr_en) bin_mem[bin_wr_addr] <= bin_wr_data;
    if (bin_rd_en) bin_rd <= bin_mem[bin_rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bdac_pkg::ST_LOAD;
      lag_min     <= 32'd0;
      lag_step    <= 32'd1;
      bins_in_use <= 7'd64;
      n_pts       <= '0;
      ovf         <= 1'b0;
      i_idx       <= '0;
      j_idx       <= '0;
      b_idx       <= '0;
      k_cnt       <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bdac_pkg::CFG_LAG_MIN:  lag_min     <= cfg_data;
          bdac_pkg::CFG_LAG_STEP: lag_step    <= cfg_data;
          bdac_pkg::CFG_BINS:     bins_in_use <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_load)              out_valid <= 1'b1;
      else if (out_ready)        out_valid <= 1'b0;

      if (in_fire) begin
        if (n_pts < bdac_pkg::PT_CW'(bdac_pkg::PTS_MAX)) n_pts <= n_pts + bdac_pkg::PT_CW'(1);
        else                                             ovf   <= 1'b1;
        if (final_point) begin
          b_idx <= '0;
          i_idx <= '0;
        end
      end
      case (state)
        bdac_pkg::ST_CLEAR:  b_idx <= b_idx + bdac_pkg::BIN_CW'(1);
        bdac_pkg::ST_W_ADD:  i_idx <= i_last ? '0 : (i_idx + bdac_pkg::PT_CW'(1));
        bdac_pkg::ST_Z_WAIT:
          if (div_done) i_idx <= i_last ? '0 : (i_idx + bdac_pkg::PT_CW'(1));
        bdac_pkg::ST_P_I:    j_idx <= i_idx;
        bdac_pkg::ST_O_START: begin
          b_idx <= '0;
          k_cnt <= '0;
        end
        bdac_pkg::ST_O_CHK:
          if (bin_rd.cnt <= 20'd1) b_idx <= b_idx + bdac_pkg::BIN_CW'(1);
        default: ;
      endcase
      if (pair_adv) begin
        if (j_last) i_idx <= i_idx + bdac_pkg::PT_CW'(1);
        else        j_idx <= j_idx + bdac_pkg::PT_CW'(1);
      end
      if (out_load) begin
        k_cnt <= k_cnt + bdac_pkg::BIN_CW'(1);
        b_idx <= b_idx + bdac_pkg::BIN_CW'(1);
        if (state == bdac_pkg::ST_O_EMPTY || k_last) begin
          // series done: back to an empty point store
          n_pts <= '0;
          ovf   <= 1'b0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (in_fire && final_point) begin
      sw    <= '0;
      acc_p <= '0;
      acc_n <= '0;
      total <= '0;
    end
    case (state)
      bdac_pkg::ST_W_WAIT: if (div_done) wq <= div_quo[47:0];
      bdac_pkg::ST_W_M1: begin
        if (rd_mneg) acc_n <= acc_n + {24'b0, prod};
        else         acc_p <= acc_p + {24'b0, prod};
      end
      bdac_pkg::ST_W_ADD: begin
        if (rd_mneg) acc_n <= acc_n + {prod[55:0], 32'b0};
        else         acc_p <= acc_p + {prod[55:0], 32'b0};
        sw <= sw + {16'b0, wq};
      end
      bdac_pkg::ST_MEAN: if (sw == 64'd0) mean <= '0;
      bdac_pkg::ST_MEAN_WAIT:
        if (div_done) mean <= acc_neg ? (26'sd0 - $signed(mq_r[25:0])) : $signed(mq_r[25:0]);
      bdac_pkg::ST_P_IL: begin
        ti <= pt_rd.ptime;
        zi <= pt_rd.data[47:16];
      end
      bdac_pkg::ST_P_BIN: zj <= pt_rd.data[47:16];
      bdac_pkg::ST_P_BWAIT: bin_a <= div_quo[bdac_pkg::BIN_AW-1:0];
      bdac_pkg::ST_P_M1: pij <= prod;
      bdac_pkg::ST_P_M2: psq <= prod;
      bdac_pkg::ST_P_UPD:
        if (bin_rd.cnt == 20'd1) total <= total + bdac_pkg::BIN_CW'(1);
      bdac_pkg::ST_O_CHK: lag_r <= lag_sat;
      bdac_pkg::ST_O_CWAIT: if (div_done) corr_r <= corr_val;
      bdac_pkg::ST_O_EWAIT: if (div_done) err_r <= div_quo[31:0];
      default: ;
    endcase
    if (out_load) begin
      points_dropped <= ovf;
      if (state == bdac_pkg::ST_O_EMPTY) begin
        lag               <= '0;
        correlation       <= '0;
        correlation_error <= '0;
        pair_count        <= '0;
        last_bin          <= 1'b1;
      end else begin
        lag               <= lag_r;
        correlation       <= corr_r;
        correlation_error <= err_r;
        pair_count        <= bin_rd.cnt;
        last_bin          <= k_last;
      end
    end
  end

endmodule

/* sv/bdac_divider.sv */
// ============================================================================
// bdac_divider
// Restoring divider, one quotient bit per cycle, over the low nbits of num.
// ============================================================================
module bdac_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  bdac_pkg::div_req_t        req,
  output logic                      done,
  output logic [bdac_pkg::DIV_W-1:0] quo,
  output logic [bdac_pkg::DIV_W-1:0] rem
);

  logic [bdac_pkg::DIV_NUM_W-1:0] num_r;
  logic [bdac_pkg::DIV_W-1:0]     den_r;
  logic [bdac_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic [bdac_pkg::DIV_W:0]       rem_sh;
  logic [bdac_pkg::DIV_W:0]       rem_dif;
  logic                           ge;

  assign rem_sh  = {rem, num_r[cnt]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_dif = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      cnt   <= req.nbits - bdac_pkg::DIV_CNT_W'(1);
      rem   <= '0;
      quo   <= '0;
    end else if (busy) begin
      rem <= ge ? rem_dif[bdac_pkg::DIV_W-1:0] : rem_sh[bdac_pkg::DIV_W-1:0];
      quo <= {quo[bdac_pkg::DIV_W-2:0], ge};
      cnt <= cnt - bdac_pkg::DIV_CNT_W'(1);
    end
  end

endmodule

/* sv/bdac_isqrt.sv */
// ============================================================================
// bdac_isqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ============================================================================
module bdac_isqrt (
  input  logic              clk,
  input  logic              rst,
  input  bdac_pkg::sq_req_t req,
  output logic              done,
  output logic [31:0]       root
);

  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      v    <= req.value;
      res  <= '0;
      bitv <= 64'h4000_0000_0000_0000;
      cnt  <= '0;
    end else if (busy) begin
      if (v >= trial) begin
        v   <= v - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt + 5'd1;
    end
  end

endmodule
